@@ design/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication into the same cycle, disabled while reset is asserted.
`define SIU_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication into the next cycle, disabled while reset is asserted.
`define SIU_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

// Implication into the next cycle, live during reset.
`define SIU_ASSERT_NEXT_RST(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ design/siu_pkg.sv @@
// Package: widths, queue entry and status types for the segment intersection unit.
`default_nettype none
package siu_pkg;
    localparam int CW          = 32;      // coordinate
    localparam int DW          = CW + 1;  // delta / offset
    localparam int PW          = 2 * DW;  // cross product term
    localparam int SW          = PW + 1;  // den, sn, tn
    localparam int MW          = PW;      // magnitudes of den and tn
    localparam int QW          = DW;      // quotient bits
    localparam int NW          = MW + QW; // tn * |delta|
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic                 hit;
        logic [MW-1:0]        tn;
        logic [MW-1:0]        den;
        logic signed [CW-1:0] ax;
        logic signed [CW-1:0] ay;
        logic signed [DW-1:0] dax;
        logic signed [DW-1:0] day;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;
endpackage
`default_nettype wire

@@ design/siu_front.sv @@
// Front end: deltas, cross products, sign normalisation and hit classification.
`default_nettype none
module siu_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire logic [255:0]    i_data,
    input  wire siu_pkg::t_q_stat i_q_stat,
    output logic                 o_push,
    output siu_pkg::t_entry      o_entry
);
    import siu_pkg::*;

    logic en;
    logic r_v1, r_v2, r_v3, r_v4;

    logic signed [CW-1:0] r_ax1, r_ay1, r_ax2, r_ay2, r_ax3, r_ay3, r_ax4, r_ay4;
    logic signed [DW-1:0] r_dax1, r_day1, r_dbx1, r_dby1, r_ox1, r_oy1;
    logic signed [DW-1:0] r_dax2, r_day2, r_dax3, r_day3, r_dax4, r_day4;
    logic signed [PW-1:0] r_pd1, r_pd2, r_ps1, r_ps2, r_pt1, r_pt2;
    logic signed [SW-1:0] r_den3, r_sn3, r_tn3, r_den4, r_sn4, r_tn4;
    logic                 r_nz4;

    logic signed [CW-1:0] w_ax1, w_ay1, w_ax2, w_ay2, w_bx1, w_by1, w_bx2, w_by2;

    assign w_ax1 = $signed(i_data[31:0]);
    assign w_ay1 = $signed(i_data[63:32]);
    assign w_ax2 = $signed(i_data[95:64]);
    assign w_ay2 = $signed(i_data[127:96]);
    assign w_bx1 = $signed(i_data[159:128]);
    assign w_by1 = $signed(i_data[191:160]);
    assign w_bx2 = $signed(i_data[223:192]);
    assign w_by2 = $signed(i_data[255:224]);

    // Stall the whole front while the last stage cannot enter the queue.
    assign en      = !r_v4 || !i_q_stat.full;
    assign o_ready = en;
    assign o_push  = en && r_v4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ax1  <= w_ax1;
            r_ay1  <= w_ay1;
            r_dax1 <= DW'(w_ax2) - DW'(w_ax1);
            r_day1 <= DW'(w_ay2) - DW'(w_ay1);
            r_dbx1 <= DW'(w_bx2) - DW'(w_bx1);
            r_dby1 <= DW'(w_by2) - DW'(w_by1);
            r_ox1  <= DW'(w_ax1) - DW'(w_bx1);
            r_oy1  <= DW'(w_ay1) - DW'(w_by1);

            r_pd1  <= r_dax1 * r_dby1;
            r_pd2  <= r_dbx1 * r_day1;
            r_ps1  <= r_dax1 * r_oy1;
            r_ps2  <= r_day1 * r_ox1;
            r_pt1  <= r_dbx1 * r_oy1;
            r_pt2  <= r_dby1 * r_ox1;
            r_ax2  <= r_ax1;
            r_ay2  <= r_ay1;
            r_dax2 <= r_dax1;
            r_day2 <= r_day1;

            r_den3 <= SW'(r_pd1) - SW'(r_pd2);
            r_sn3  <= SW'(r_ps1) - SW'(r_ps2);
            r_tn3  <= SW'(r_pt1) - SW'(r_pt2);
            r_ax3  <= r_ax2;
            r_ay3  <= r_ay2;
            r_dax3 <= r_dax2;
            r_day3 <= r_day2;

            // Flip signs so that the denominator is non-negative.
            r_nz4  <= r_den3 != '0;
            r_den4 <= r_den3[SW-1] ? -r_den3 : r_den3;
            r_sn4  <= r_den3[SW-1] ? -r_sn3 : r_sn3;
            r_tn4  <= r_den3[SW-1] ? -r_tn3 : r_tn3;
            r_ax4  <= r_ax3;
            r_ay4  <= r_ay3;
            r_dax4 <= r_dax3;
            r_day4 <= r_day3;
        end
    end

    always_comb begin
        o_entry.hit = r_nz4 && !r_sn4[SW-1] && !r_tn4[SW-1]
                      && (r_den4 >= r_sn4) && (r_den4 >= r_tn4);
        o_entry.tn  = r_tn4[MW-1:0];
        o_entry.den = r_den4[MW-1:0];
        o_entry.ax  = r_ax4;
        o_entry.ay  = r_ay4;
        o_entry.dax = r_dax4;
        o_entry.day = r_day4;
    end
endmodule
`default_nettype wire

@@ design/siu_queue.sv @@
// Short queue between the front and back ends.
`default_nettype none
module siu_queue #(
    parameter int DEPTH = siu_pkg::QUEUE_DEPTH
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire siu_pkg::t_entry i_entry,
    input  wire logic            i_pop,
    output siu_pkg::t_entry      o_entry,
    output siu_pkg::t_q_stat     o_stat
);
    import siu_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NC = $clog2(DEPTH + 1);

    t_entry        r_mem [0:DEPTH-1];
    logic [AW-1:0] r_wr, r_rd;
    logic [NC-1:0] r_cnt;

    assign o_stat.full  = r_cnt == NC'(DEPTH);
    assign o_stat.empty = r_cnt == '0;
    assign o_entry      = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_entry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            if (i_pop)  r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            if (i_push && !i_pop)      r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 1'b1;
        end
    end
endmodule
`default_nettype wire

@@ design/siu_back.sv @@
// Back end: point numerator products, pipelined restoring divide and output register.
`default_nettype none
module siu_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire siu_pkg::t_entry  i_entry,
    input  wire siu_pkg::t_q_stat i_q_stat,
    output logic                  o_pop,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic                  o_hit,
    output logic [31:0]           o_cross_x,
    output logic [31:0]           o_cross_y
);
    import siu_pkg::*;

    logic en;
    logic r_v1;

    logic                 r_hit1;
    logic [MW-1:0]        r_den1;
    logic signed [CW-1:0] r_ax1, r_ay1;
    logic                 r_nx1, r_ny1;
    logic [PW-1:0]        r_pxl, r_pxh, r_pyl, r_pyh;
    logic [DW-1:0]        w_magx, w_magy;

    logic                 r_dv   [0:QW];
    logic                 r_dhit [0:QW];
    logic [MW-1:0]        r_dden [0:QW];
    logic signed [CW-1:0] r_dax  [0:QW];
    logic signed [CW-1:0] r_day  [0:QW];
    logic                 r_dnx  [0:QW];
    logic                 r_dny  [0:QW];
    logic [MW-1:0]        r_remx [0:QW];
    logic [MW-1:0]        r_remy [0:QW];
    logic [QW-1:0]        r_lowx [0:QW];
    logic [QW-1:0]        r_lowy [0:QW];
    logic [QW-1:0]        r_qx   [0:QW];
    logic [QW-1:0]        r_qy   [0:QW];

    logic [NW-1:0]        w_nx, w_ny;
    logic [DW-1:0]        w_fx, w_fy;

    logic                 r_ov, r_ohit;
    logic [CW-1:0]        r_ox, r_oy;

    assign en    = !r_ov || i_ready;
    assign o_pop = en && !i_q_stat.empty;

    assign w_magx = i_entry.dax[DW-1] ? DW'(-i_entry.dax) : DW'(i_entry.dax);
    assign w_magy = i_entry.day[DW-1] ? DW'(-i_entry.day) : DW'(i_entry.day);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v1 <= !i_q_stat.empty;
        end
    end

    // Split tn into two halves so that each product stays within one multiplier.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hit1 <= i_entry.hit;
            r_den1 <= i_entry.den;
            r_ax1  <= i_entry.ax;
            r_ay1  <= i_entry.ay;
            r_nx1  <= i_entry.dax[DW-1];
            r_ny1  <= i_entry.day[DW-1];
            r_pxl  <= PW'(i_entry.tn[DW-1:0]) * PW'(w_magx);
            r_pxh  <= PW'(i_entry.tn[MW-1:DW]) * PW'(w_magx);
            r_pyl  <= PW'(i_entry.tn[DW-1:0]) * PW'(w_magy);
            r_pyh  <= PW'(i_entry.tn[MW-1:DW]) * PW'(w_magy);
        end
    end

    assign w_nx = {r_pxh, {DW{1'b0}}} + NW'(r_pxl);
    assign w_ny = {r_pyh, {DW{1'b0}}} + NW'(r_pyl);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else if (en) begin
            r_dv[0] <= r_v1;
        end
    end

    // The quotient never exceeds |delta|, so the top numerator bits start as remainder.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dhit[0] <= r_hit1;
            r_dden[0] <= r_den1;
            r_dax[0]  <= r_ax1;
            r_day[0]  <= r_ay1;
            r_dnx[0]  <= r_nx1;
            r_dny[0]  <= r_ny1;
            r_remx[0] <= w_nx[NW-1:QW];
            r_remy[0] <= w_ny[NW-1:QW];
            r_lowx[0] <= w_nx[QW-1:0];
            r_lowy[0] <= w_ny[QW-1:0];
            r_qx[0]   <= '0;
            r_qy[0]   <= '0;
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_div
        logic [MW:0] w_tx, w_ty, w_dx, w_dy, w_d;
        logic        w_gx, w_gy;

        assign w_d  = {1'b0, r_dden[k]};
        assign w_tx = {r_remx[k], r_lowx[k][QW-1]};
        assign w_ty = {r_remy[k], r_lowy[k][QW-1]};
        assign w_gx = w_tx >= w_d;
        assign w_gy = w_ty >= w_d;
        assign w_dx = w_tx - w_d;
        assign w_dy = w_ty - w_d;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[k+1] <= 1'b0;
            end else if (en) begin
                r_dv[k+1] <= r_dv[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dhit[k+1] <= r_dhit[k];
                r_dden[k+1] <= r_dden[k];
                r_dax[k+1]  <= r_dax[k];
                r_day[k+1]  <= r_day[k];
                r_dnx[k+1]  <= r_dnx[k];
                r_dny[k+1]  <= r_dny[k];
                r_remx[k+1] <= w_gx ? w_dx[MW-1:0] : w_tx[MW-1:0];
                r_remy[k+1] <= w_gy ? w_dy[MW-1:0] : w_ty[MW-1:0];
                r_lowx[k+1] <= {r_lowx[k][QW-2:0], 1'b0};
                r_lowy[k+1] <= {r_lowy[k][QW-2:0], 1'b0};
                r_qx[k+1]   <= {r_qx[k][QW-2:0], w_gx};
                r_qy[k+1]   <= {r_qy[k][QW-2:0], w_gy};
            end
        end
    end

    assign w_fx = r_dnx[QW] ? DW'(r_dax[QW]) - r_qx[QW] : DW'(r_dax[QW]) + r_qx[QW];
    assign w_fy = r_dny[QW] ? DW'(r_day[QW]) - r_qy[QW] : DW'(r_day[QW]) + r_qy[QW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= r_dv[QW];
        end
    end

    // Zero the point on a miss.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ohit <= r_dhit[QW];
            r_ox   <= r_dhit[QW] ? w_fx[CW-1:0] : '0;
            r_oy   <= r_dhit[QW] ? w_fy[CW-1:0] : '0;
        end
    end

    assign o_valid   = r_ov;
    assign o_hit     = r_ohit;
    assign o_cross_x = r_ox;
    assign o_cross_y = r_oy;
endmodule
`default_nettype wire

@@ design/segment_intersection_unit.sv @@
// Top level of the segment intersection unit.
// Tests two 2-D segments in signed Q16.16 for intersection and returns the crossing point.
// One pair is taken per cycle while o_s_tready is high; each yields one result, in order.
// A pair passes through four front stages (deltas, products, numerators, sign fix and
// classification), the queue, two product stages, 33 divider stages that each settle
// one quotient bit for x and y, and the output register.
// The divider pipeline sets throughput: a new pair each cycle unless the output stalls.
// Output tuser carries hit; the point is zero on a miss.
`default_nettype none
module segment_intersection_unit #(
    parameter int QUEUE_DEPTH = siu_pkg::QUEUE_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_tvalid,
    output logic               o_s_tready,
    // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
    input  wire logic [255:0]  i_s_tdata,
    output logic               o_m_tvalid,
    input  wire logic          i_m_tready,
    // cross_x, cross_y
    output logic [63:0]        o_m_tdata,
    // hit
    output logic               o_m_tuser
);
    import siu_pkg::*;

    t_entry  w_fe_entry, w_q_entry;
    t_q_stat w_q_stat;
    logic    w_push, w_pop;
    logic [CW-1:0] w_cx, w_cy;

    siu_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .o_ready  (o_s_tready),
        .i_data   (i_s_tdata),
        .i_q_stat (w_q_stat),
        .o_push   (w_push),
        .o_entry  (w_fe_entry)
    );

    siu_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_fe_entry),
        .i_pop   (w_pop),
        .o_entry (w_q_entry),
        .o_stat  (w_q_stat)
    );

    siu_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_entry   (w_q_entry),
        .i_q_stat  (w_q_stat),
        .o_pop     (w_pop),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_hit     (o_m_tuser),
        .o_cross_x (w_cx),
        .o_cross_y (w_cy)
    );

    assign o_m_tdata = {w_cy, w_cx};
endmodule
`default_nettype wire

@@ design/siu_checker.sv @@
// Port-level checker for the segment intersection unit, with its bind.
`default_nettype none
`include "assert_macros.svh"
module siu_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          i_s_tvalid,
    input wire logic          o_s_tready,
    input wire logic [255:0]  i_s_tdata,
    input wire logic          o_m_tvalid,
    input wire logic          i_m_tready,
    input wire logic [63:0]   o_m_tdata,
    input wire logic          o_m_tuser
);
    `SIU_ASSERT_NEXT_RST(a_rst_clears_out, i_clk, !i_rst_n, !o_m_tvalid)
    `SIU_ASSERT_SAME(a_miss_zero_point, i_clk, i_rst_n, o_m_tvalid && !o_m_tuser, o_m_tdata == 64'd0)
    `SIU_ASSERT_NEXT(a_out_held, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid)
    `SIU_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, $stable(o_m_tdata) && $stable(o_m_tuser))
endmodule

bind segment_intersection_unit siu_checker u_siu_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
`default_nettype wire

@@ tb/tb.sv @@
// Testbench for the segment intersection unit: queued random and directed stimulus, predicted results.
`timescale 1ns / 100ps
`default_nettype none
module tb;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 100;

    typedef struct packed {
        logic signed [31:0] by2;
        logic signed [31:0] bx2;
        logic signed [31:0] by1;
        logic signed [31:0] bx1;
        logic signed [31:0] ay2;
        logic signed [31:0] ax2;
        logic signed [31:0] ay1;
        logic signed [31:0] ax1;
    } t_pair;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] cy;
        logic signed [31:0] cx;
    } t_crossing;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_s_tvalid = 1'b0;
    logic          o_s_tready;
    logic [255:0]  i_s_tdata = '0;
    logic          o_m_tvalid;
    logic          i_m_tready = 1'b0;
    logic [63:0]   o_m_tdata;
    logic          o_m_tuser;

    t_pair     pending_pairs[$];
    t_crossing expected_crossings[$];
    int        error_count = 0;
    int        idle_cycles = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    int        hold_off = 0;

    segment_intersection_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always #1 i_clk = ~i_clk;

    // Exact crossing test on wide signed integers; 140 bits covers every product.
    function automatic t_crossing predict_crossing(t_pair p);
        logic signed [139:0] dax, day, dbx, dby, ox, oy, den, sn, tn;
        t_crossing r;
        dax = p.ax2 - p.ax1;
        day = p.ay2 - p.ay1;
        dbx = p.bx2 - p.bx1;
        dby = p.by2 - p.by1;
        ox  = p.ax1 - p.bx1;
        oy  = p.ay1 - p.by1;
        den = dax * dby - dbx * day;
        sn  = dax * oy - day * ox;
        tn  = dbx * oy - dby * ox;
        r = '0;
        if (den == 0) return r;
        if (den < 0) begin
            den = -den;
            sn  = -sn;
            tn  = -tn;
        end
        if (sn < 0 || tn < 0 || sn > den || tn > den) return r;
        r.hit = 1'b1;
        // Signed division in SystemVerilog truncates toward zero.
        r.cx = 32'(p.ax1 + (tn * dax) / den);
        r.cy = 32'(p.ay1 + (tn * day) / den);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        error_count++;
    endtask

    function automatic logic [31:0] random_coord();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000 + $urandom_range(0, 3);
            1: return 32'h7fff_ffff - $urandom_range(0, 3);
            2: return $urandom_range(0, 40) << 16;
            3: return -($urandom_range(0, 40) << 16);
            4: return $signed($urandom_range(0, 2000)) - 1000;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_pair random_pair();
        t_pair p;
        int k;
        logic signed [31:0] mx, my;
        k = $urandom_range(0, 9);
        if (k < 5) begin
            // likely crossing: both segments pass near a common point
            mx = $signed($urandom_range(0, 4000)) - 2000;
            my = $signed($urandom_range(0, 4000)) - 2000;
            p.ax1 = mx - $urandom_range(1, 3000); p.ay1 = my - $urandom_range(0, 3000);
            p.ax2 = mx + $urandom_range(0, 3000); p.ay2 = my + $urandom_range(1, 3000);
            p.bx1 = mx + $urandom_range(0, 3000); p.by1 = my - $urandom_range(1, 3000);
            p.bx2 = mx - $urandom_range(1, 3000); p.by2 = my + $urandom_range(0, 3000);
            if ($urandom_range(0, 3) == 0) begin
                p.ax1 = p.ax1 <<< 12; p.ay1 = p.ay1 <<< 12; p.ax2 = p.ax2 <<< 12;
                p.ay2 = p.ay2 <<< 12; p.bx1 = p.bx1 <<< 12; p.by1 = p.by1 <<< 12;
                p.bx2 = p.bx2 <<< 12; p.by2 = p.by2 <<< 12;
            end
        end else if (k == 5) begin
            // parallel: B is A shifted
            p.ax1 = $urandom; p.ay1 = $urandom; p.ax2 = $urandom; p.ay2 = $urandom;
            mx = $urandom_range(0, 500); my = $urandom_range(0, 500);
            p.bx1 = p.ax1 + mx; p.by1 = p.ay1 + my; p.bx2 = p.ax2 + mx; p.by2 = p.ay2 + my;
        end else if (k == 6) begin
            p = {$urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom};
        end else begin
            p.ax1 = random_coord(); p.ay1 = random_coord();
            p.ax2 = random_coord(); p.ay2 = random_coord();
            p.bx1 = random_coord(); p.by1 = random_coord();
            p.bx2 = random_coord(); p.by2 = random_coord();
        end
        return p;
    endfunction

    function automatic t_pair make_pair(int ax1, int ay1, int ax2, int ay2,
                                        int bx1, int by1, int bx2, int by2);
        t_pair p;
        p.ax1 = ax1; p.ay1 = ay1; p.ax2 = ax2; p.ay2 = ay2;
        p.bx1 = bx1; p.by1 = by1; p.bx2 = bx2; p.by2 = by2;
        return p;
    endfunction

    // Sender: offer the head of the queue, advance on each transaction.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                expected_crossings.push_back(predict_crossing(t_pair'(i_s_tdata)));
                void'(pending_pairs.pop_front());
            end
            if (pending_pairs.size() > 0 && (!(i_s_tvalid && o_s_tready) || 1)) begin
                if (i_s_tvalid && !o_s_tready) begin
                    // hold the offered item until taken
                end else if (pending_pairs.size() > 0 &&
                             $urandom_range(1, 100) > send_idle_pct) begin
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= pending_pairs[0];
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: check each transaction against the oldest prediction.
    always @(posedge i_clk) begin
        t_crossing want;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                if (expected_crossings.size() == 0) begin
                    report_mismatch("unexpected result", o_m_tdata, '0);
                end else begin
                    want = expected_crossings.pop_front();
                    if (o_m_tuser !== want.hit)
                        report_mismatch("hit", 64'(o_m_tuser), 64'(want.hit));
                    if (o_m_tdata[31:0] !== want.cx)
                        report_mismatch("cross_x", 64'(o_m_tdata[31:0]), 64'(want.cx));
                    if (o_m_tdata[63:32] !== want.cy)
                        report_mismatch("cross_y", 64'(o_m_tdata[63:32]), 64'(want.cy));
                end
            end
            if (hold_off > 0) begin
                hold_off   <= hold_off - 1;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= $urandom_range(1, 100) > recv_stall_pct;
            end
        end
    end

    // Watchdog: count cycles with no transaction on either side.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles <= 0;
        end else if (i_rst_n) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: errors");
                $finish;
            end
        end
    end

    task automatic run_phase(int n, int send_pct, int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        repeat (n) pending_pairs.push_back(random_pair());
        while (pending_pairs.size() > 0) @(posedge i_clk);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // directed: crossings, endpoint touches, parallel, collinear, degenerate, extremes
        pending_pairs.push_back(make_pair(0, 0, 'h20000, 'h20000, 0, 'h20000, 'h20000, 0));
        pending_pairs.push_back(make_pair(0, 0, 'h10000, 0, 'h10000, 0, 'h10000, 'h10000));
        pending_pairs.push_back(make_pair(0, 0, 'h10000, 0, 0, 0, 0, 'h10000));
        pending_pairs.push_back(make_pair(0, 0, 'h10000, 0, 0, 'h10000, 'h10000, 'h10000));
        pending_pairs.push_back(make_pair(0, 0, 'h20000, 0, 'h10000, 0, 'h30000, 0));
        pending_pairs.push_back(make_pair(5, 5, 5, 5, 0, 0, 10, 10));
        pending_pairs.push_back(make_pair(0, 0, 'h10000, 'h10000, 'h30000, 0, 'h20000, 'h10000));
        pending_pairs.push_back(make_pair(0, 0, 'h10000, 'h10000, 'h10001, 0, 'h10001, 'h10000));
        pending_pairs.push_back(make_pair(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
            32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000));
        pending_pairs.push_back(make_pair(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
            32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff));
        pending_pairs.push_back(make_pair(32'h8000_0000, 0, 32'h7fff_ffff, 3, 0,
            32'h8000_0000, 7, 32'h7fff_ffff));
        pending_pairs.push_back(make_pair(-1, -1, 1, 2, 2, -3, -3, 1));
        pending_pairs.push_back(make_pair('1, '1, '1, '1, '1, '1, '1, '1));
        pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
        run_phase(0, 0, 0);
        run_phase(200, 0, 0);
        run_phase(200, 46, 0);
        run_phase(200, 0, 46);
        // long receiver hold-off while the sender keeps offering
        hold_off = 300;
        run_phase(60, 0, 0);
        run_phase(200, 31, 31);
        while (expected_crossings.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && expected_crossings.size() == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end
endmodule
`default_nettype wire
